FILE: hdl/sacmc_pkg.sv
// Package with types and constants shared by the cache miss classifier.
`default_nettype none
package sacmc_pkg;
  localparam int unsigned MAX_SETS_DEF = 256;
  localparam int unsigned MAX_WAYS_DEF = 8;

  localparam logic [1:0] OUT_HIT        = 2'd0;
  localparam logic [1:0] OUT_COMPULSORY = 2'd1;
  localparam logic [1:0] OUT_CONFLICT   = 2'd2;
  localparam logic [1:0] OUT_CAPACITY   = 2'd3;

  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;
  localparam logic [1:0] REG_POLICY = 2'd3;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  random_way;
  } in_word_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [2:0] way_used;
    logic [7:0] set_index;
  } out_word_t;
endpackage
`default_nettype wire

FILE: hdl/set_assoc_cache_miss_classifier_core.sv
// Set-associative cache lookup that classifies every access as hit or miss kind.
// Usage: one input word (address, random_way) on in_valid/in_ready, one result word
// (outcome, way_used, set_index) on out_valid/out_ready. Registers are to be written
// by the user on cfg_we with cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this. For each access the set is read from the tag, valid
// and stamp memories into registers when the word is accepted (one row per set, all
// ways side by side); in the execute state the tags are compared, the oldest stamp is
// picked and the row is written back. A new word is taken only once the output register
// is empty. The stamp search runs over the ways as a short chain of compares in the
// execute state. After reset a clearing pass sweeps the valid and stamp rows, one set
// per cycle, over all MAX_SETS sets; no word is accepted during it. Configuration
// writes are taken throughout. When the receiver stalls, the result is held in the
// output register and no further word is accepted until it has been taken.
`default_nettype none
module set_assoc_cache_miss_classifier_core #(
  parameter int unsigned MAX_SETS = sacmc_pkg::MAX_SETS_DEF,
  parameter int unsigned MAX_WAYS = sacmc_pkg::MAX_WAYS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sacmc_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sacmc_pkg::out_word_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [4:0]           cfg_data
);
  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int CW = SW + WW + 2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  logic [4:0] offset_bits;
  logic [3:0] index_bits;
  logic [3:0] ways_in_use;
  logic [1:0] policy;
  logic [31:0] access_count;
  logic [CW-1:0] filled_count;
  logic [SW-1:0] clr_ptr;

  logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];
  logic [MAX_WAYS*32-1:0] tag_mem [MAX_SETS];
  logic [MAX_WAYS*32-1:0] stamp_mem [MAX_SETS];
  logic [MAX_WAYS-1:0] valid_rd;
  logic [MAX_WAYS*32-1:0] tag_rd, stamp_rd;

  // Decoded geometry.
  logic [4:0] ib;
  logic [5:0] ways;
  logic [16:0] sets;
  logic [SW-1:0] set_a;
  logic [31:0] tag_a;
  logic [5:0] shift;

  always_comb begin
    ib = (32'(index_bits) > LIM) ? 5'(LIM) : {1'b0, index_bits};
    if (ways_in_use == 4'd0) ways = 6'd1;
    else if (32'(ways_in_use) > MAX_WAYS) ways = 6'(MAX_WAYS);
    else ways = {2'b0, ways_in_use};
    sets = 17'd1 << ib;
    set_a = SW'((in_data.address >> offset_bits) & 32'(sets - 17'd1));
    shift = {1'b0, offset_bits} + {1'b0, ib};
    tag_a = shift[5] ? 32'd0 : (in_data.address >> shift[4:0]);
  end

  // Latched request.
  logic [SW-1:0] set_r;
  logic [31:0] tag_r;
  logic [2:0] rnd_r;
  logic [31:0] cnt_now;

  logic accept;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  // Lookup on the row read back.
  logic hit, has_inv;
  logic [WW-1:0] hit_way, inv_way, old_way, vict_way, way_sel;
  logic [31:0] old_stamp;
  logic [3:0] rnd_mod;
  logic [1:0] outcome_c;
  logic [MAX_WAYS-1:0] valid_wr;
  logic [MAX_WAYS*32-1:0] tag_wr, stamp_wr;
  logic wr_tag, wr_stamp, fill;

  always_comb begin
    hit = 1'b0; hit_way = '0; has_inv = 1'b0; inv_way = '0;
    old_way = '0; old_stamp = stamp_rd[31:0];
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(ways)) begin
        if (valid_rd[w] && tag_rd[w*32 +: 32] == tag_r) begin
          hit = 1'b1; hit_way = WW'(w);
        end
        if (!valid_rd[w]) begin
          has_inv = 1'b1; inv_way = WW'(w);
        end
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (w < 32'(ways) && stamp_rd[w*32 +: 32] < old_stamp) begin
        old_stamp = stamp_rd[w*32 +: 32]; old_way = WW'(w);
      end
    end
    // The random choice is below eight, so with two or more ways three
    // conditional subtractions reduce it below the way count.
    rnd_mod = {1'b0, rnd_r};
    if (ways == 6'd1) begin
      rnd_mod = 4'd0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (6'(rnd_mod) >= ways) rnd_mod = rnd_mod - ways[3:0];
      end
    end
    vict_way = (policy == sacmc_pkg::POL_RANDOM) ? WW'(rnd_mod) : old_way;
    fill = 1'b0;
    if (hit) begin
      way_sel = hit_way; outcome_c = sacmc_pkg::OUT_HIT;
      wr_tag = 1'b0; wr_stamp = (policy == sacmc_pkg::POL_LRU);
    end else if (has_inv) begin
      way_sel = inv_way; outcome_c = sacmc_pkg::OUT_COMPULSORY;
      wr_tag = 1'b1; wr_stamp = 1'b1; fill = 1'b1;
    end else begin
      way_sel = vict_way; wr_tag = 1'b1; wr_stamp = 1'b1;
      if (ways == 6'd1) outcome_c = sacmc_pkg::OUT_CONFLICT;
      else if (sets == 17'd1) outcome_c = sacmc_pkg::OUT_CAPACITY;
      else if (32'(filled_count) < 32'(sets) * 32'(ways))
        outcome_c = sacmc_pkg::OUT_CONFLICT;
      else outcome_c = sacmc_pkg::OUT_CAPACITY;
    end
    valid_wr = valid_rd; tag_wr = tag_rd; stamp_wr = stamp_rd;
    if (fill) valid_wr[way_sel] = 1'b1;
    if (wr_tag) tag_wr[32*way_sel +: 32] = tag_r;
    if (wr_stamp) stamp_wr[32*way_sel +: 32] = cnt_now;
  end

  // Memories: one row read and one row written per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      valid_rd <= valid_mem[set_a];
      tag_rd <= tag_mem[set_a];
      stamp_rd <= stamp_mem[set_a];
    end
    if (state == ST_CLEAR) begin
      valid_mem[clr_ptr] <= '0;
      stamp_mem[clr_ptr] <= '0;
    end else if (state == ST_EXEC) begin
      valid_mem[set_r] <= valid_wr;
      tag_mem[set_r] <= tag_wr;
      stamp_mem[set_r] <= stamp_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= set_a; tag_r <= tag_a; rnd_r <= in_data.random_way;
      cnt_now <= (access_count == '1) ? access_count : access_count + 32'd1;
    end
    if (state == ST_EXEC) begin
      out_data.outcome <= outcome_c;
      out_data.way_used <= 3'(way_sel);
      out_data.set_index <= 8'(set_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; clr_ptr <= '0; out_valid <= 1'b0;
      offset_bits <= 5'd2; index_bits <= 4'd0; ways_in_use <= 4'd1;
      policy <= sacmc_pkg::POL_LRU; access_count <= '0; filled_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sacmc_pkg::REG_OFFSET: offset_bits <= cfg_data;
          sacmc_pkg::REG_INDEX:  index_bits <= cfg_data[3:0];
          sacmc_pkg::REG_WAYS:   ways_in_use <= cfg_data[3:0];
          sacmc_pkg::REG_POLICY: policy <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + SW'(1);
          if (32'(clr_ptr) == MAX_SETS - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
            if (access_count != '1) access_count <= access_count + 32'd1;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE; out_valid <= 1'b1;
          if (fill) filled_count <= filled_count + CW'(1);
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("accept during clear");
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> out_valid) else $error("result lost");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC) else $error("accept not executed");
endmodule
`default_nettype wire

FILE: sim/sacmc_checker.sv
// Checker that predicts the cache classifier's results and compares them on the output channel.
module sacmc_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  sacmc_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  sacmc_pkg::out_word_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = sacmc_pkg::MAX_SETS_DEF;
  localparam int NWAYS = sacmc_pkg::MAX_WAYS_DEF;

  logic [4:0]  offset_bits;
  logic [3:0]  index_bits;
  logic [3:0]  ways_in_use;
  logic [1:0]  policy;
  logic        line_valid [NSETS*NWAYS];
  logic [31:0] line_tag   [NSETS*NWAYS];
  logic [31:0] line_stamp [NSETS*NWAYS];
  logic [31:0] access_count;
  int unsigned filled_count;
  sacmc_pkg::out_word_t expected_q [$];

  function automatic sacmc_pkg::out_word_t classify_access(sacmc_pkg::in_word_t w);
    sacmc_pkg::out_word_t r;
    int unsigned ib, ways, sets, set, shift, base, way, lowest_way;
    logic [31:0] tag, oldest;
    bit hit, filled;
    ib = (index_bits > 8) ? 8 : index_bits;
    ways = (ways_in_use == 0) ? 1 : ((ways_in_use > NWAYS) ? NWAYS : ways_in_use);
    sets = 1 << ib;
    set = (w.address >> offset_bits) & (sets - 1);
    shift = offset_bits + ib;
    tag = (shift >= 32) ? 32'd0 : (w.address >> shift);
    base = set * NWAYS;
    hit = 0;
    filled = 0;
    way = 0;
    r.outcome = sacmc_pkg::OUT_HIT;
    if (access_count != 32'hFFFF_FFFF) access_count++;
    for (int i = 0; i < ways && !hit; i++) begin
      if (line_valid[base+i] && line_tag[base+i] == tag) begin
        hit = 1;
        way = i;
        if (policy == sacmc_pkg::POL_LRU) line_stamp[base+i] = access_count;
      end
    end
    if (!hit) begin
      for (int i = 0; i < ways && !filled; i++) begin
        if (!line_valid[base+i]) begin
          line_valid[base+i] = 1;
          line_tag[base+i] = tag;
          line_stamp[base+i] = access_count;
          filled_count++;
          filled = 1;
          way = i;
          r.outcome = sacmc_pkg::OUT_COMPULSORY;
        end
      end
      if (!filled) begin
        if (ways == 1) r.outcome = sacmc_pkg::OUT_CONFLICT;
        else if (sets == 1) r.outcome = sacmc_pkg::OUT_CAPACITY;
        else r.outcome = (filled_count < sets * ways) ? sacmc_pkg::OUT_CONFLICT
                                                      : sacmc_pkg::OUT_CAPACITY;
        if (policy == sacmc_pkg::POL_RANDOM) begin
          way = w.random_way % ways;
        end else begin
          // Strict compare keeps the lowest way among equal stamps.
          oldest = line_stamp[base];
          lowest_way = 0;
          for (int i = 1; i < ways; i++) begin
            if (line_stamp[base+i] < oldest) begin
              oldest = line_stamp[base+i];
              lowest_way = i;
            end
          end
          way = lowest_way;
        end
        line_tag[base+way] = tag;
        line_stamp[base+way] = access_count;
      end
    end
    r.way_used = way[2:0];
    r.set_index = set[7:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    sacmc_pkg::out_word_t e;
    if (rst) begin
      offset_bits <= 5'd2;
      index_bits <= 4'd0;
      ways_in_use <= 4'd1;
      policy <= sacmc_pkg::POL_LRU;
      for (int i = 0; i < NSETS*NWAYS; i++) begin
        line_valid[i] = 0;
        line_tag[i] = 0;
        line_stamp[i] = 0;
      end
      access_count = 0;
      filled_count = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sacmc_pkg::REG_OFFSET: offset_bits <= cfg_data;
          sacmc_pkg::REG_INDEX:  index_bits <= cfg_data[3:0];
          sacmc_pkg::REG_WAYS:   ways_in_use <= cfg_data[3:0];
          sacmc_pkg::REG_POLICY: policy <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(classify_access(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("checker: unexpected word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10)
              $display("checker: expected outcome %0d way %0d set %0d, got %0d %0d %0d",
                       e.outcome, e.way_used, e.set_index,
                       out_data.outcome, out_data.way_used, out_data.set_index);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: sim/tb.sv
// Testbench top: drives accesses and register writes into the cache classifier.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  sacmc_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sacmc_pkg::out_word_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  int        fail_count;
  int        pending;
  bit        stall_mode;

  set_assoc_cache_miss_classifier_core i_dut (.*);

  sacmc_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Receiver stalls; phases with no stalls alternate with stalling ones.
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (stall_mode) out_ready <= (gap_length() == 0);
    else out_ready <= 1;
  end

  // Valid stays high after the accepting edge; a gap or the next drain drops it.
  task automatic send_word(logic [31:0] addr, logic [2:0] rw);
    int g;
    g = stall_mode ? gap_length() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{address: addr, random_way: rw};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(logic [4:0] ob, logic [3:0] ib, logic [3:0] ways,
                              logic [1:0] pol);
    drain();
    write_reg(sacmc_pkg::REG_OFFSET, ob);
    write_reg(sacmc_pkg::REG_INDEX, {1'b0, ib});
    write_reg(sacmc_pkg::REG_WAYS, {1'b0, ways});
    write_reg(sacmc_pkg::REG_POLICY, {3'b0, pol});
    cfg_we <= 0;
  endtask

  // Addresses from a small pool of tags so that sets fill and evict.
  task automatic random_phase(int count, int tags);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) a = $urandom();
      else a = $urandom_range(0, tags - 1) * 32'h0000_0104 + ($urandom() & 32'h3);
      send_word(a, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = sacmc_pkg::REG_OFFSET;
    cfg_data = '0;
    stall_mode = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: reset geometry, then extremes of the address and all policies.
    send_word(32'h0000_0000, 3'd0);
    send_word(32'hFFFF_FFFF, 3'd7);
    send_word(32'h0000_0000, 3'd0);
    set_geometry(5'd31, 4'd15, 4'd0, sacmc_pkg::POL_FIFO);
    send_word(32'h8000_0000, 3'd5);
    send_word(32'h7FFF_FFFF, 3'd2);
    set_geometry(5'd0, 4'd8, 4'd15, 2'd3);
    for (int i = 0; i < 10; i++) send_word(32'h100 * i + 32'h5, i[2:0]);
    set_geometry(5'd2, 4'd0, 4'd4, sacmc_pkg::POL_RANDOM);
    for (int i = 0; i < 6; i++) send_word(32'h40 * i, 3'd7 - i[2:0]);
    set_geometry(5'd2, 4'd1, 4'd2, sacmc_pkg::POL_LRU);
    send_word(32'h0, 3'd0);
    send_word(32'h8, 3'd0);
    send_word(32'h0, 3'd0);
    send_word(32'h10, 3'd0);

    for (int ph = 0; ph < 16; ph++) begin
      stall_mode = ph[0];
      set_geometry(5'($urandom_range(0, 6)), 4'($urandom_range(0, 3)),
                   4'($urandom_range(1, 8)), 2'($urandom_range(0, 3)));
      random_phase(90, $urandom_range(4, 40));
    end
    stall_mode = 1;
    set_geometry(5'd31, 4'd8, 4'd8, sacmc_pkg::POL_RANDOM);
    random_phase(40, 30);

    drain();
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
